// ===== rtl/core/xsfd_pkg.sv =====
package xsfd_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCRAMBLE_KEY    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_LENGTH = 1'b1;

  // Register reset values
  localparam logic [31:0] SCRAMBLE_KEY_RESET     = 32'h02B8_FE2B;
  localparam logic [15:0] MAX_FRAME_LENGTH_RESET = 16'd4092;

  // Header size in bytes; payload length is frame length minus this
  localparam logic [15:0] HEADER_LENGTH = 16'd4;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_EMPTY_CMD  = 2'd1,
    KIND_BAD_LENGTH = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] command_id;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        last;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ===== rtl/core/xsfd_frame.sv =====
module xsfd_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   abort,
  input  logic [31:0]            scramble_key,
  input  logic [15:0]            max_frame_length,
  output logic                   res_valid,
  output xsfd_pkg::result_t      res
);
  import xsfd_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [15:0] length_hold, length_hold_next;
  logic [15:0] command_hold, command_hold_next;
  logic [15:0] payload_position, payload_position_next;

  logic [1:0]  key_sel;
  logic [7:0]  key_byte;
  logic [7:0]  clear_byte;
  logic [1:0]  hc_eff;
  logic [15:0] final_pos;
  logic        pay_last;

  // Pick the key byte: header count in header phase, payload position in payload phase, key byte 0 otherwise
  always_comb begin
    hc_eff  = (phase == PH_HEADER) ? header_count : 2'd0;
    key_sel = (phase == PH_PAYLOAD) ? payload_position[1:0] : hc_eff;
    case (key_sel)
      2'd0:    key_byte = scramble_key[7:0];
      2'd1:    key_byte = scramble_key[15:8];
      2'd2:    key_byte = scramble_key[23:16];
      default: key_byte = scramble_key[31:24];
    endcase
    clear_byte = data_byte ^ key_byte;
    final_pos  = length_hold - (HEADER_LENGTH + 16'd1);
    pay_last   = (payload_position >= final_pos);
  end

  // Next state and result for one byte
  always_comb begin
    phase_next            = phase;
    header_count_next     = header_count;
    length_hold_next      = length_hold;
    command_hold_next     = command_hold;
    payload_position_next = payload_position;
    res_valid             = 1'b0;
    res.kind              = KIND_PAYLOAD;
    res.payload_byte      = 8'd0;
    res.byte_index        = 16'd0;
    res.last              = 1'b1;

    if (abort) begin
      phase_next            = PH_HEADER;
      header_count_next     = 2'd0;
      length_hold_next      = 16'd0;
      command_hold_next     = 16'd0;
      payload_position_next = 16'd0;
    end else begin
      unique case (phase)
        PH_ERROR: begin
          // drop bytes until abort
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = clear_byte;
          res.byte_index   = payload_position;
          res.last         = pay_last;
          if (pay_last) begin
            phase_next            = PH_HEADER;
            header_count_next     = 2'd0;
            payload_position_next = 16'd0;
          end else begin
            payload_position_next = payload_position + 16'd1;
          end
        end
        default: begin
          // Header byte; an unknown phase code acts as a fresh header
          phase_next = PH_HEADER;
          case (hc_eff)
            2'd0:    length_hold_next  = {length_hold[15:8], clear_byte};
            2'd1:    length_hold_next  = {clear_byte, length_hold[7:0]};
            2'd2:    command_hold_next = {command_hold[15:8], clear_byte};
            default: command_hold_next = {clear_byte, command_hold[7:0]};
          endcase
          if (hc_eff != 2'd3) begin
            header_count_next = hc_eff + 2'd1;
          end else begin
            header_count_next     = 2'd0;
            payload_position_next = 16'd0;
            if (length_hold < HEADER_LENGTH || length_hold > max_frame_length) begin
              phase_next = PH_ERROR;
              res_valid  = 1'b1;
              res.kind   = KIND_BAD_LENGTH;
            end else if (length_hold == HEADER_LENGTH) begin
              res_valid = 1'b1;
              res.kind  = KIND_EMPTY_CMD;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      endcase
    end

    // Result tags carry the header as it stands after this byte
    res.command_id   = command_hold_next;
    res.frame_length = length_hold_next;
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_count     <= 2'd0;
      length_hold      <= 16'd0;
      command_hold     <= 16'd0;
      payload_position <= 16'd0;
    end else if (step) begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      length_hold      <= length_hold_next;
      command_hold     <= command_hold_next;
      payload_position <= payload_position_next;
    end
  end

endmodule

// ===== rtl/core/xor_scrambled_frame_deframer.sv =====
// Path: an accepted byte waits in the input register; its result, if it makes one, is held in the
//   result register that drives m_*, and m_tready low stalls both stages.
// Throughput: one byte per cycle while m_tready does not stall the result side; an input
//   register and a result register part the two sides, and the frame state updates once per byte.
// Reset (rst, synchronous): frame state returns to the header phase, both stages empty,
//   key and maximum length return to their defaults.
module xor_scrambled_frame_deframer (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] data_byte
  input  logic                                s_tuser,  // [0] abort
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [55:0]                         m_tdata,  // [15:0] command_id,
                                                        // [23:16] payload_byte,
                                                        // [39:24] byte_index,
                                                        // [55:40] frame_length
  output logic [1:0]                          m_tuser,  // [1:0] kind
  output logic                                m_tlast,  // last
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [xsfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data
);
  import xsfd_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_abort;
  logic        out_valid;
  result_t     out_res;
  logic        advance;
  logic        step;
  logic        res_valid;
  result_t     res;
  logic [31:0] scramble_key;
  logic [15:0] max_frame_length;

  assign advance   = !out_valid || m_tready;
  assign step      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scramble_key     <= SCRAMBLE_KEY_RESET;
      max_frame_length <= MAX_FRAME_LENGTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCRAMBLE_KEY:     scramble_key     <= cfg_data;
        CFG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register: take a request whenever the stage is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_abort <= s_tuser;
    end
  end

  xsfd_frame u_frame (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .data_byte        (in_byte),
    .abort            (in_abort),
    .scramble_key     (scramble_key),
    .max_frame_length (max_frame_length),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.frame_length, out_res.byte_index,
                     out_res.payload_byte, out_res.command_id};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;

endmodule
